@@ src/avcl_pkg.sv @@
// Shared constants, codes and types for the variable-record cache lookup block.
// Used by the interfaces, the slot cells, the controller and the top level.
package avcl_pkg;

  localparam int CACHE_SLOTS = 128;
  localparam int REF_BITS    = 16;
  localparam int IDX_W       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int AGE_W       = 31;
  localparam int SLOT_W      = 7;
  localparam int LOCK_W      = 4;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_NOVICTIM = 2'd2,
    ST_LOCK     = 2'd3
  } status_t;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_LOCK   = 1'b1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [REF_BITS-1:0] ref_t;
  typedef logic [AGE_W-1:0]    age_t;
  typedef logic [LOCK_W-1:0]   lock_t;

  // Token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic active;
    logic hit;
    idx_t hit_idx;
    logic found;
    idx_t best_idx;
    age_t best_age;
    ref_t best_tag;
  } sweep_t;

  // Write broadcast from the controller to all cells.
  typedef struct packed {
    logic  tag_we;
    logic  lock_we;
    idx_t  idx;
    ref_t  tag;
    age_t  age;
    lock_t lock;
  } wr_t;

endpackage

@@ src/avcl_if.sv @@
// Handshake interfaces for lookup requests and results.
// Depends on avcl_pkg for field widths.
interface avcl_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [avcl_pkg::REF_BITS-1:0] ref_req;
  logic [avcl_pkg::SLOT_W-1:0]   slot_sel;
  logic [avcl_pkg::LOCK_W-1:0]   lock_value;

  modport source (output valid, req_type, ref_req, slot_sel, lock_value, input ready);
  modport sink   (input valid, req_type, ref_req, slot_sel, lock_value, output ready);
endinterface

interface avcl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [avcl_pkg::STATUS_W-1:0] status;
  logic [avcl_pkg::SLOT_W-1:0]   slot;
  logic                          writeback_valid;
  logic [avcl_pkg::REF_BITS-1:0] writeback_ref;

  modport source (output valid, status, slot, writeback_valid, writeback_ref, input ready);
  modport sink   (input valid, status, slot, writeback_valid, writeback_ref, output ready);
endinterface

@@ src/avcl_cell.sv @@
// One cache slot: tag, load age and lock count, plus one stage of the search row.
// Depends on avcl_pkg.
module avcl_cell (
  input  logic             clk,
  input  logic             rst,
  input  avcl_pkg::idx_t   cell_idx,
  input  avcl_pkg::ref_t   lookup_ref,
  input  avcl_pkg::wr_t    wr,
  input  avcl_pkg::sweep_t sweep_in,
  output avcl_pkg::sweep_t sweep_out
);

  avcl_pkg::ref_t   tag;
  avcl_pkg::age_t   age;
  avcl_pkg::lock_t  lock;
  avcl_pkg::sweep_t sweep_next;
  logic             match;
  logic             eligible;

  assign match    = (tag == lookup_ref);
  assign eligible = (tag == '0) || (lock == '0);

  always_comb begin
    sweep_next = sweep_in;
    if (sweep_in.active) begin
      if (match && !sweep_in.hit) begin
        sweep_next.hit     = 1'b1;
        sweep_next.hit_idx = cell_idx;
      end
      // strict less keeps the lowest index on a tie
      if (eligible && (!sweep_in.found || (age < sweep_in.best_age))) begin
        sweep_next.found    = 1'b1;
        sweep_next.best_idx = cell_idx;
        sweep_next.best_age = age;
        sweep_next.best_tag = tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag       <= '0;
      age       <= '0;
      lock      <= '0;
      sweep_out <= '0;
    end else begin
      sweep_out <= sweep_next;
      if (wr.tag_we && (wr.idx == cell_idx)) begin
        tag <= wr.tag;
        age <= wr.age;
      end
      if (wr.lock_we && (wr.idx == cell_idx)) begin
        lock <= wr.lock;
      end
    end
  end

endmodule

@@ src/avcl_ctrl.sv @@
// Request decode, sweep launch, victim install, age counter and result register.
// Depends on avcl_pkg and the avcl_req_if / avcl_rsp_if interfaces.
module avcl_ctrl (
  input  logic             clk,
  input  logic             rst,
  avcl_req_if.sink         req,
  avcl_rsp_if.source       rsp,
  output avcl_pkg::sweep_t tok_start,
  input  avcl_pkg::sweep_t tok_end,
  output avcl_pkg::wr_t    wr,
  output avcl_pkg::ref_t   lookup_ref
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SWEEP = 2'b10
  } state_t;

  state_t                    state;
  state_t                    state_next;
  avcl_pkg::age_t            age_counter;
  avcl_pkg::age_t            age_inc;
  avcl_pkg::sweep_t          tok_start_next;
  logic                      accept;
  logic                      lock_in_range;

  logic                      out_valid;
  avcl_pkg::status_t         out_status;
  logic [avcl_pkg::SLOT_W-1:0] out_slot;
  logic                      out_wbv;
  avcl_pkg::ref_t            out_wbr;

  assign req.ready     = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept        = req.valid && req.ready;
  assign age_inc       = age_counter + 1'b1;
  assign lock_in_range = (32'(req.slot_sel) < avcl_pkg::CACHE_SLOTS);

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.slot            = out_slot;
  assign rsp.writeback_valid = out_wbv;
  assign rsp.writeback_ref   = out_wbr;

  always_comb begin
    tok_start_next        = '0;
    tok_start_next.active = accept && (req.req_type == avcl_pkg::REQ_LOOKUP) &&
                            (req.ref_req != '0);
  end

  always_comb begin
    wr         = '0;
    wr.lock_we = accept && (req.req_type == avcl_pkg::REQ_LOCK) && lock_in_range;
    wr.lock    = req.lock_value;
    wr.idx     = avcl_pkg::IDX_W'(req.slot_sel);
    wr.tag     = lookup_ref;
    wr.age     = age_inc;
    if (tok_end.active && !tok_end.hit && tok_end.found) begin
      wr.tag_we = 1'b1;
      wr.idx    = tok_end.best_idx;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (tok_start_next.active) state_next = S_SWEEP;
      S_SWEEP: if (tok_end.active) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      age_counter <= '0;
      tok_start   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      tok_start <= tok_start_next;
      if ((accept && !tok_start_next.active) || tok_end.active) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      if (wr.tag_we) age_counter <= age_inc;
    end
  end

  // Payload registers: hold the lookup reference and the result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      lookup_ref <= req.ref_req;
      out_wbv    <= 1'b0;
      out_wbr    <= '0;
      if (req.req_type == avcl_pkg::REQ_LOCK) begin
        out_status <= avcl_pkg::ST_LOCK;
        out_slot   <= req.slot_sel;
      end else begin
        out_status <= avcl_pkg::ST_NOVICTIM;
        out_slot   <= '0;
      end
    end else if (tok_end.active) begin
      if (tok_end.hit) begin
        out_status <= avcl_pkg::ST_HIT;
        out_slot   <= avcl_pkg::SLOT_W'(tok_end.hit_idx);
        out_wbv    <= 1'b0;
        out_wbr    <= '0;
      end else if (tok_end.found) begin
        out_status <= avcl_pkg::ST_MISS;
        out_slot   <= avcl_pkg::SLOT_W'(tok_end.best_idx);
        out_wbv    <= (tok_end.best_tag != '0);
        out_wbr    <= tok_end.best_tag;
      end else begin
        out_status <= avcl_pkg::ST_NOVICTIM;
        out_slot   <= '0;
        out_wbv    <= 1'b0;
        out_wbr    <= '0;
      end
    end
  end

  a_end_in_sweep: assert property (@(posedge clk) disable iff (rst)
    tok_end.active |-> (state == S_SWEEP))
    else $error("sweep token left the row outside a sweep");

  a_single_launch: assert property (@(posedge clk) disable iff (rst)
    tok_start.active |=> !tok_start.active)
    else $error("sweep launched twice in a row");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(accept) || $past(tok_end.active)))
    else $error("result appeared without a request or a finished sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    tok_end.active |-> !out_valid)
    else $error("sweep finished while a result was still pending");

endmodule

@@ src/assoc_var_cache_lookup.sv @@
// Lookup of a reference passes a search token from the start register across the row of
// slot cells, one cell per cycle, and then into the result register.
// A lock request or a zero reference gives its result in the cycle after acceptance.
// One request at a time: the next is taken once the result is taken, or in that cycle.
// Synchronous reset clears all tags, ages, lock counts and the age counter at once.
module assoc_var_cache_lookup (
  input  logic       clk,
  input  logic       rst,
  avcl_req_if.sink   req,
  avcl_rsp_if.source rsp
);

  avcl_pkg::sweep_t tok [avcl_pkg::CACHE_SLOTS+1];
  avcl_pkg::wr_t    wr;
  avcl_pkg::ref_t   lookup_ref;

  avcl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .tok_start  (tok[0]),
    .tok_end    (tok[avcl_pkg::CACHE_SLOTS]),
    .wr         (wr),
    .lookup_ref (lookup_ref)
  );

  for (genvar i = 0; i < avcl_pkg::CACHE_SLOTS; i++) begin : g_cell
    avcl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (avcl_pkg::IDX_W'(i)),
      .lookup_ref (lookup_ref),
      .wr         (wr),
      .sweep_in   (tok[i]),
      .sweep_out  (tok[i+1])
    );
  end

endmodule

@@ tb/sv/avcl_lookup_checker.sv @@
// Result checker for the variable-record cache lookup block: watches both handshake
// channels, keeps its own tags, load ages and lock counts, and compares every result.
// Depends on avcl_pkg and the avcl_req_if / avcl_rsp_if interfaces.
`timescale 1ns / 100ps

module avcl_lookup_checker
  import avcl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  avcl_req_if  req,
  avcl_rsp_if  rsp,
  output int   errors,
  output int   outstanding,
  output int   hits,
  output int   fills,
  output int   writebacks,
  output int   refusals,
  output int   lock_updates
);

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              wb_valid;
    ref_t              wb_ref;
  } lookup_result_t;

  ref_t  tag_store [CACHE_SLOTS];
  age_t  age_store [CACHE_SLOTS];
  lock_t pin_store [CACHE_SLOTS];
  age_t  load_counter;

  lookup_result_t awaited_results [$];

  int fault_count;
  int hit_count;
  int fill_count;
  int writeback_count;
  int refusal_count;
  int lock_count;

  // Apply one request to the shadow cache and return the result it must produce.
  function automatic lookup_result_t resolve_request(logic kind, ref_t tag,
                                                     logic [SLOT_W-1:0] sel, lock_t pins);
    lookup_result_t res;
    int             i;
    int             victim;
    age_t           victim_age;
    res.status   = ST_NOVICTIM;
    res.slot     = '0;
    res.wb_valid = 1'b0;
    res.wb_ref   = '0;
    victim       = -1;
    victim_age   = '0;
    if (kind == REQ_LOCK) begin
      if (int'(sel) < CACHE_SLOTS) pin_store[sel] = pins;
      res.status = ST_LOCK;
      res.slot   = sel;
      return res;
    end
    // the block launches no sweep for a zero reference: refuse it outright
    if (tag == '0) return res;
    for (i = 0; i < CACHE_SLOTS; i++) begin
      if (tag_store[i] == tag) begin
        res.status = ST_HIT;
        res.slot   = SLOT_W'(i);
        return res;
      end
    end
    // empty slots stay eligible even with a lock count; strict minimum keeps lowest index
    for (i = 0; i < CACHE_SLOTS; i++) begin
      if ((tag_store[i] == '0 || pin_store[i] == '0) &&
          (victim < 0 || age_store[i] < victim_age)) begin
        victim     = i;
        victim_age = age_store[i];
      end
    end
    if (victim < 0) return res;
    load_counter      = load_counter + 1'b1;
    res.status        = ST_MISS;
    res.slot          = SLOT_W'(victim);
    res.wb_valid      = (tag_store[victim] != '0);
    res.wb_ref        = tag_store[victim];
    age_store[victim] = load_counter;
    tag_store[victim] = tag;
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    int             i;
    if (rst) begin
      for (i = 0; i < CACHE_SLOTS; i++) begin
        tag_store[i] = '0;
        age_store[i] = '0;
        pin_store[i] = '0;
      end
      load_counter = '0;
      awaited_results.delete();
    end else begin
      // retire the result first: a new request cannot produce a result at its own edge
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected result: status %0d slot %0d wb %0b ref %h",
                     $time, rsp.status, rsp.slot, rsp.writeback_valid, rsp.writeback_ref);
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status || rsp.slot !== want.slot ||
              rsp.writeback_valid !== want.wb_valid || rsp.writeback_ref !== want.wb_ref) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: mismatch (exp/act): status %0d/%0d slot %0d/%0d wb %0b/%0b ref %h/%h",
                       $time, want.status, rsp.status, want.slot, rsp.slot,
                       want.wb_valid, rsp.writeback_valid, want.wb_ref, rsp.writeback_ref);
          end
          case (want.status)
            ST_HIT:      hit_count++;
            ST_MISS: begin
              fill_count++;
              if (want.wb_valid) writeback_count++;
            end
            ST_NOVICTIM: refusal_count++;
            default:     lock_count++;
          endcase
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(resolve_request(req.req_type, req.ref_req,
                                                  req.slot_sel, req.lock_value));
    end
    errors       <= fault_count;
    outstanding  <= awaited_results.size();
    hits         <= hit_count;
    fills        <= fill_count;
    writebacks   <= writeback_count;
    refusals     <= refusal_count;
    lock_updates <= lock_count;
  end

endmodule

@@ tb/sv/assoc_var_cache_lookup_test.sv @@
// Top of the cache lookup testbench: clock, reset, request stimulus and response stalls.
// Depends on avcl_pkg, the avcl interfaces, assoc_var_cache_lookup and avcl_lookup_checker.
`timescale 1ns / 100ps

module assoc_var_cache_lookup_test;
  import avcl_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int POOL_SIZE    = 200;
  localparam int HOT_REFS     = 40;
  localparam int DRAIN_CYCLES = CACHE_SLOTS + 12;
  localparam int IDLE_PCT     = 28;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;

  int cycle_count = 0;
  int sent = 0;
  int errors;
  int outstanding;
  int hits;
  int fills;
  int writebacks;
  int refusals;
  int lock_updates;

  ref_t ref_pool [POOL_SIZE];

  avcl_req_if req ();
  avcl_rsp_if rsp ();

  assoc_var_cache_lookup DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  avcl_lookup_checker watch (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .errors       (errors),
    .outstanding  (outstanding),
    .hits         (hits),
    .fills        (fills),
    .writebacks   (writebacks),
    .refusals     (refusals),
    .lock_updates (lock_updates)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("assoc_var_cache_lookup verification failed");
      $finish;
    end
  end

  // Hold the request until the block takes it; valid stays high into the next one.
  task automatic issue_request(logic kind, ref_t tag, logic [SLOT_W-1:0] sel, lock_t pins);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.ref_req    <= tag;
    req.slot_sel   <= sel;
    req.lock_value <= pins;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic lookup_ref(ref_t tag);
    issue_request(REQ_LOOKUP, tag, SLOT_W'($urandom), LOCK_W'($urandom));
  endtask

  task automatic set_pins(logic [SLOT_W-1:0] sel, lock_t pins);
    issue_request(REQ_LOCK, REF_BITS'($urandom), sel, pins);
  endtask

  // Favor a small hot set so that hits are common.
  function automatic ref_t pool_ref();
    if ($urandom_range(1) == 0) return ref_pool[$urandom_range(HOT_REFS - 1)];
    return ref_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // Pin every slot, try lookups against a cache with every slot pinned, then release most pins.
  task automatic pin_every_slot();
    int s;
    for (s = 0; s < CACHE_SLOTS; s++) set_pins(SLOT_W'(s), LOCK_W'($urandom_range(1, 15)));
    repeat (6) lookup_ref(REF_BITS'($urandom_range(1, 65535)));
    repeat (6) lookup_ref(pool_ref());
    for (s = 0; s < CACHE_SLOTS; s++)
      set_pins(SLOT_W'(s), ($urandom_range(3) == 0) ? LOCK_W'($urandom) : '0);
  endtask

  initial begin
    int i;
    int pick;
    int first_random;
    int done_random;
    int bursts_run;
    req.valid      <= 1'b0;
    req.req_type   <= REQ_LOOKUP;
    req.ref_req    <= '0;
    req.slot_sel   <= '0;
    req.lock_value <= '0;
    bursts_run = 0;
    for (i = 0; i < POOL_SIZE; i++) ref_pool[i] = REF_BITS'($urandom_range(1, 65535));
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening: extremes, zero reference, pinned and empty-but-pinned slots
    lookup_ref(16'hFFFF);
    lookup_ref(16'hFFFF);
    lookup_ref(16'h0000);
    lookup_ref(16'h0001);
    set_pins(7'd127, 4'hF);
    set_pins(7'd0, 4'hF);
    set_pins(7'd1, 4'h0);
    lookup_ref(16'h8000);
    set_pins(7'd2, 4'hA);
    set_pins(7'd1, 4'h5);
    lookup_ref(16'h5555);
    lookup_ref(16'hAAAA);
    lookup_ref(16'h0001);
    set_pins(7'd85, 4'h5);
    set_pins(7'd0, 4'h0);
    set_pins(7'd1, 4'h0);
    set_pins(7'd2, 4'h0);
    set_pins(7'd127, 4'h0);
    lookup_ref(16'h7FFF);
    lookup_ref(16'hFFFF);

    first_random = sent;
    done_random  = 0;
    while (done_random < RANDOM_ITEMS) begin
      calm <= (done_random >= 150 && done_random < 400);
      if (bursts_run < 2 && done_random >= 420 + 480 * bursts_run) begin
        pin_every_slot();
        bursts_run++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 55)      lookup_ref(pool_ref());
        else if (pick < 70) lookup_ref(REF_BITS'($urandom_range(1, 65535)));
        else if (pick < 73) lookup_ref('0);
        else if ($urandom_range(99) < 55) set_pins(SLOT_W'($urandom), '0);
        else set_pins(SLOT_W'($urandom), LOCK_W'($urandom_range(1, 15)));
      end
      done_random = sent - first_random;
    end
    req.valid <= 1'b0;
    calm      <= 1'b0;

    // let the checker see the last acceptance before trusting its count
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d hits, %0d fills (%0d with writeback),",
             sent, hits, fills, writebacks);
    $display("  %0d refused, %0d lock updates", refusals, lock_updates);
    if (errors == 0) begin
      $display("assoc_var_cache_lookup verification clean");
    end else begin
      $display("assoc_var_cache_lookup verification failed");
    end
    $finish;
  end

endmodule
